[design/e2r_pkg.sv]
// ----------------------------------------------------------------------------
// e2r_pkg
// Shared constants, types and tables for the Euler angle to rotation basis
// block: CORDIC arctangent table, fixed-point widths and result types.
// ----------------------------------------------------------------------------
`default_nettype none

package e2r_pkg;

    // binary angle width, fraction bits of the results, CORDIC iterations
    localparam int ANGLE_BITS  = 16;
    localparam int FRAC_BITS   = 14;
    localparam int TRIG_STAGES = 16;

    // cordic datapath widths
    localparam int XY_W  = 35;
    localparam int Z_W   = 33;
    localparam int Q30_W = 32;
    localparam int PROD_W = 64;
    localparam int SUM_W = 34;
    localparam int TERM_W = 16;

    // lane registers: init, iterations, post; merge registers: five
    localparam int LANE_REGS  = TRIG_STAGES + 2;
    localparam int MERGE_REGS = 5;
    localparam int PIPE_REGS  = LANE_REGS + MERGE_REGS;

    localparam longint INV_GAIN_Q32 = 64'sd2608131496;
    localparam longint ONE_Q32      = 64'sd1 <<< 32;
    localparam longint PROD_BIAS    = 64'sd1 <<< 29;

    localparam int     OUT_SHIFT = 30 - FRAC_BITS;
    localparam longint OUT_BIAS  = (64'sd1 <<< OUT_SHIFT) >>> 1;
    localparam longint ONE_OUT   = 64'sd1 <<< FRAC_BITS;

    // arctan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] ATAN_TURN [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quad;

    typedef logic [15:0]               t_angle;
    typedef logic signed [Q30_W-1:0]   t_q30;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [SUM_W-1:0]   t_sum;
    typedef logic signed [TERM_W-1:0]  t_term;

    typedef struct packed {
        t_term i_x;
        t_term i_y;
        t_term i_z;
        t_term j_x;
        t_term j_y;
        t_term j_z;
        t_term k_x;
        t_term k_y;
        t_term k_z;
    } t_basis;

endpackage

`default_nettype wire

[design/e2r_in_if.sv]
// ----------------------------------------------------------------------------
// e2r_in_if
// Request channel: one yaw, pitch, roll triple with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface e2r_in_if;
    import e2r_pkg::*;

    logic   valid;
    logic   ready;
    t_angle yaw_angle;
    t_angle pitch_angle;
    t_angle roll_angle;

    modport source (
        output valid,
        output yaw_angle,
        output pitch_angle,
        output roll_angle,
        input  ready
    );

    modport sink (
        input  valid,
        input  yaw_angle,
        input  pitch_angle,
        input  roll_angle,
        output ready
    );

endinterface

`default_nettype wire

[design/e2r_out_if.sv]
// ----------------------------------------------------------------------------
// e2r_out_if
// Result channel: nine Q1.14 rotation basis terms with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface e2r_out_if;
    import e2r_pkg::*;

    logic  valid;
    logic  ready;
    t_term i_x;
    t_term i_y;
    t_term i_z;
    t_term j_x;
    t_term j_y;
    t_term j_z;
    t_term k_x;
    t_term k_y;
    t_term k_z;

    modport source (
        output valid,
        output i_x, i_y, i_z,
        output j_x, j_y, j_z,
        output k_x, k_y, k_z,
        input  ready
    );

    modport sink (
        input  valid,
        input  i_x, i_y, i_z,
        input  j_x, j_y, j_z,
        input  k_x, k_y, k_z,
        output ready
    );

endinterface

`default_nettype wire

[design/e2r_cordic_lane.sv]
// ----------------------------------------------------------------------------
// e2r_cordic_lane
// Pipelined rotation-mode CORDIC for one binary angle: one register per
// iteration, then clamp, rounding to Q30 and quadrant mapping.
// ----------------------------------------------------------------------------
`default_nettype none

module e2r_cordic_lane (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  e2r_pkg::t_angle    i_angle,
    output e2r_pkg::t_q30      o_cos,
    output e2r_pkg::t_q30      o_sin
);
    import e2r_pkg::*;

    logic signed [XY_W-1:0] r_x [TRIG_STAGES+1];
    logic signed [XY_W-1:0] r_y [TRIG_STAGES+1];
    logic signed [Z_W-1:0]  r_z [TRIG_STAGES+1];
    t_quad                  r_quad [TRIG_STAGES+1];

    logic signed [XY_W-1:0] n_x [TRIG_STAGES];
    logic signed [XY_W-1:0] n_y [TRIG_STAGES];
    logic signed [Z_W-1:0]  n_z [TRIG_STAGES];

    logic [31:0]            w_turn;
    logic signed [XY_W-1:0] w_xc;
    logic signed [XY_W-1:0] w_yc;
    t_q30                   w_c;
    t_q30                   w_s;
    t_q30                   n_cos;
    t_q30                   n_sin;
    t_q30                   r_cos;
    t_q30                   r_sin;

    // angle placed in the top bits of a 32-bit turn
    assign w_turn = 32'(i_angle) << (32 - ANGLE_BITS);

    always_comb begin
        for (int k = 0; k < TRIG_STAGES; k++) begin
            if (!r_z[k][Z_W-1]) begin
                n_x[k] = r_x[k] - (r_y[k] >>> k);
                n_y[k] = r_y[k] + (r_x[k] >>> k);
                n_z[k] = r_z[k] - Z_W'(ATAN_TURN[k]);
            end else begin
                n_x[k] = r_x[k] + (r_y[k] >>> k);
                n_y[k] = r_y[k] - (r_x[k] >>> k);
                n_z[k] = r_z[k] + Z_W'(ATAN_TURN[k]);
            end
        end
    end

    always_comb begin
        // clamp to +-1.0 at Q32
        if (r_x[TRIG_STAGES] > XY_W'(ONE_Q32)) begin
            w_xc = XY_W'(ONE_Q32);
        end else if (r_x[TRIG_STAGES] < -XY_W'(ONE_Q32)) begin
            w_xc = -XY_W'(ONE_Q32);
        end else begin
            w_xc = r_x[TRIG_STAGES];
        end
        if (r_y[TRIG_STAGES] > XY_W'(ONE_Q32)) begin
            w_yc = XY_W'(ONE_Q32);
        end else if (r_y[TRIG_STAGES] < -XY_W'(ONE_Q32)) begin
            w_yc = -XY_W'(ONE_Q32);
        end else begin
            w_yc = r_y[TRIG_STAGES];
        end
        w_c = Q30_W'((w_xc + XY_W'(2)) >>> 2);
        w_s = Q30_W'((w_yc + XY_W'(2)) >>> 2);
        case (r_quad[TRIG_STAGES])
            QUAD_0: begin
                n_cos = w_c;
                n_sin = w_s;
            end
            QUAD_1: begin
                n_cos = -w_s;
                n_sin = w_c;
            end
            QUAD_2: begin
                n_cos = -w_c;
                n_sin = -w_s;
            end
            default: begin
                n_cos = w_s;
                n_sin = -w_c;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= XY_W'(INV_GAIN_Q32);
            r_y[0]    <= '0;
            r_z[0]    <= Z_W'(w_turn[29:0]);
            r_quad[0] <= t_quad'(w_turn[31:30]);
            for (int k = 0; k < TRIG_STAGES; k++) begin
                r_x[k+1]    <= n_x[k];
                r_y[k+1]    <= n_y[k];
                r_z[k+1]    <= n_z[k];
                r_quad[k+1] <= r_quad[k];
            end
            r_cos <= n_cos;
            r_sin <= n_sin;
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

`default_nettype wire

[design/e2r_merge.sv]
// ----------------------------------------------------------------------------
// e2r_merge
// Combines the three lanes' cosine and sine into the nine basis terms:
// pair products, rounding, triple products, sums, final rounding and
// saturation to Q1.FRAC_BITS.
// ----------------------------------------------------------------------------
`default_nettype none

module e2r_merge (
    input  wire logic       i_clk,
    input  wire logic       i_en,
    input  e2r_pkg::t_q30   i_cy,
    input  e2r_pkg::t_q30   i_sy,
    input  e2r_pkg::t_q30   i_cp,
    input  e2r_pkg::t_q30   i_sp,
    input  e2r_pkg::t_q30   i_cr,
    input  e2r_pkg::t_q30   i_sr,
    output e2r_pkg::t_basis o_basis
);
    import e2r_pkg::*;

    function automatic t_prod mul(input t_q30 a, input t_q30 b);
        return t_prod'(a) * t_prod'(b);
    endfunction

    // Q60 product rounded half up to Q30
    function automatic t_q30 rnd30(input t_prod p);
        t_prod b;
        b = p + t_prod'(PROD_BIAS);
        return t_q30'(b >>> 30);
    endfunction

    function automatic t_term to_out(input t_sum v);
        t_sum r;
        r = (v + t_sum'(OUT_BIAS)) >>> OUT_SHIFT;
        if (r > t_sum'(ONE_OUT)) begin
            r = t_sum'(ONE_OUT);
        end else if (r < -t_sum'(ONE_OUT)) begin
            r = -t_sum'(ONE_OUT);
        end
        return t_term'(r);
    endfunction

    // stage 1: raw pair products
    t_prod r1_cycp, r1_sycp, r1_sycr, r1_srcy, r1_cycr, r1_sysp;
    t_prod r1_cpsr, r1_sysr, r1_cysp, r1_cysr, r1_crcp;
    t_q30  r1_sp, r1_sr, r1_cr;

    // stage 2: rounded pair products
    t_q30  r2_cycp, r2_sycp, r2_sycr, r2_srcy, r2_cycr, r2_sysp;
    t_q30  r2_cpsr, r2_sysr, r2_cysp, r2_cysr, r2_crcp;
    t_q30  r2_sp, r2_sr, r2_cr;

    // stage 3: raw triple products, pairs carried along
    t_prod r3_jx, r3_jy, r3_kx, r3_ky;
    t_q30  r3_cycp, r3_sycp, r3_sp, r3_sycr, r3_cycr;
    t_q30  r3_cpsr, r3_sysr, r3_cysr, r3_crcp;

    // stage 4: Q30 terms
    t_sum  r4_ix, r4_iy, r4_iz, r4_jx, r4_jy, r4_jz, r4_kx, r4_ky, r4_kz;

    t_basis r_basis;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_cycp <= mul(i_cy, i_cp);
            r1_sycp <= mul(i_sy, i_cp);
            r1_sycr <= mul(i_sy, i_cr);
            r1_srcy <= mul(i_sr, i_cy);
            r1_cycr <= mul(i_cy, i_cr);
            r1_sysp <= mul(i_sy, i_sp);
            r1_cpsr <= mul(i_cp, i_sr);
            r1_sysr <= mul(i_sy, i_sr);
            r1_cysp <= mul(i_cy, i_sp);
            r1_cysr <= mul(i_cy, i_sr);
            r1_crcp <= mul(i_cr, i_cp);
            r1_sp   <= i_sp;
            r1_sr   <= i_sr;
            r1_cr   <= i_cr;

            r2_cycp <= rnd30(r1_cycp);
            r2_sycp <= rnd30(r1_sycp);
            r2_sycr <= rnd30(r1_sycr);
            r2_srcy <= rnd30(r1_srcy);
            r2_cycr <= rnd30(r1_cycr);
            r2_sysp <= rnd30(r1_sysp);
            r2_cpsr <= rnd30(r1_cpsr);
            r2_sysr <= rnd30(r1_sysr);
            r2_cysp <= rnd30(r1_cysp);
            r2_cysr <= rnd30(r1_cysr);
            r2_crcp <= rnd30(r1_crcp);
            r2_sp   <= r1_sp;
            r2_sr   <= r1_sr;
            r2_cr   <= r1_cr;

            r3_jx   <= mul(r2_srcy, r2_sp);
            r3_jy   <= mul(r2_sysp, r2_sr);
            r3_kx   <= mul(r2_cysp, r2_cr);
            r3_ky   <= mul(r2_sysp, r2_cr);
            r3_cycp <= r2_cycp;
            r3_sycp <= r2_sycp;
            r3_sp   <= r2_sp;
            r3_sycr <= r2_sycr;
            r3_cycr <= r2_cycr;
            r3_cpsr <= r2_cpsr;
            r3_sysr <= r2_sysr;
            r3_cysr <= r2_cysr;
            r3_crcp <= r2_crcp;

            r4_ix <= t_sum'(r3_cycp);
            r4_iy <= t_sum'(r3_sycp);
            r4_iz <= -t_sum'(r3_sp);
            r4_jx <= t_sum'(rnd30(r3_jx)) - t_sum'(r3_sycr);
            r4_jy <= t_sum'(r3_cycr) + t_sum'(rnd30(r3_jy));
            r4_jz <= t_sum'(r3_cpsr);
            r4_kx <= t_sum'(r3_sysr) + t_sum'(rnd30(r3_kx));
            r4_ky <= t_sum'(rnd30(r3_ky)) - t_sum'(r3_cysr);
            r4_kz <= t_sum'(r3_crcp);

            r_basis.i_x <= to_out(r4_ix);
            r_basis.i_y <= to_out(r4_iy);
            r_basis.i_z <= to_out(r4_iz);
            r_basis.j_x <= to_out(r4_jx);
            r_basis.j_y <= to_out(r4_jy);
            r_basis.j_z <= to_out(r4_jz);
            r_basis.k_x <= to_out(r4_kx);
            r_basis.k_y <= to_out(r4_ky);
            r_basis.k_z <= to_out(r4_kz);
        end
    end

    assign o_basis = r_basis;

endmodule

`default_nettype wire

[design/euler_to_rotation_matrix_core.sv]
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix_core
// Yaw, pitch, roll binary angles to the nine Z-Y-X rotation basis terms.
// Three CORDIC lanes run side by side, a merge pipeline forms the products.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  i_req    | in  | valid / ready | yaw_angle, pitch_angle, roll_angle (16b)
//  o_res    | out | valid / ready | i_x..k_z, nine signed Q1.14 terms
//
//  one request per cycle sustained while the skid register is empty; the
//  path runs through the per-iteration CORDIC registers and five merge stages
//  reset clears the pipeline valid bits and the skid-full flag
//  a stalled result moves into the skid register; the pipeline holds only
//  while the skid register is full, and ready is a registered signal
// ----------------------------------------------------------------------------
`default_nettype none

module euler_to_rotation_matrix_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    e2r_in_if.sink    i_req,
    e2r_out_if.source o_res
);
    import e2r_pkg::*;

    logic                 w_en;
    logic [PIPE_REGS-1:0] r_valid;
    logic                 r_skid_full;
    t_basis               r_skid;
    t_basis               w_basis;
    t_basis               w_out;
    logic                 w_last;

    t_q30 w_cy, w_sy, w_cp, w_sp, w_cr, w_sr;

    assign w_en   = !r_skid_full;
    assign w_last = r_valid[PIPE_REGS-1];

    assign i_req.ready = w_en;

    e2r_cordic_lane u_yaw (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (i_req.yaw_angle),
        .o_cos   (w_cy),
        .o_sin   (w_sy)
    );

    e2r_cordic_lane u_pitch (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (i_req.pitch_angle),
        .o_cos   (w_cp),
        .o_sin   (w_sp)
    );

    e2r_cordic_lane u_roll (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (i_req.roll_angle),
        .o_cos   (w_cr),
        .o_sin   (w_sr)
    );

    e2r_merge u_merge (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_cy    (w_cy),
        .i_sy    (w_sy),
        .i_cp    (w_cp),
        .i_sp    (w_sp),
        .i_cr    (w_cr),
        .i_sr    (w_sr),
        .o_basis (w_basis)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_en) begin
            r_valid <= {r_valid[PIPE_REGS-2:0], i_req.valid};
        end
    end

    // skid catches the last stage when the sink stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_full <= 1'b0;
        end else if (r_skid_full) begin
            if (o_res.ready) begin
                r_skid_full <= 1'b0;
            end
        end else if (w_last && !o_res.ready) begin
            r_skid_full <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_full && w_last && !o_res.ready) begin
            r_skid <= w_basis;
        end
    end

    assign w_out = r_skid_full ? r_skid : w_basis;

    assign o_res.valid = r_skid_full || w_last;
    assign o_res.i_x   = w_out.i_x;
    assign o_res.i_y   = w_out.i_y;
    assign o_res.i_z   = w_out.i_z;
    assign o_res.j_x   = w_out.j_x;
    assign o_res.j_y   = w_out.j_y;
    assign o_res.j_z   = w_out.j_z;
    assign o_res.k_x   = w_out.k_x;
    assign o_res.k_y   = w_out.k_y;
    assign o_res.k_z   = w_out.k_z;

endmodule

`default_nettype wire

[test/e2r_checker.sv]
// ----------------------------------------------------------------------------
// e2r_checker
// Watches the request and result channels of the Euler angle to rotation
// basis core, predicts the nine Q1.14 basis terms of every accepted request
// with its own CORDIC and product model, and compares each accepted result
// with the oldest prediction.
// ----------------------------------------------------------------------------
module e2r_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    e2r_in_if    i_req,
    e2r_out_if   i_res,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import e2r_pkg::*;

    localparam longint GAIN_COMP_Q32 = 64'sd2608131496;
    localparam longint UNIT_Q32      = 64'sd1 <<< 32;
    localparam int     MAX_REPORTS   = 10;

    localparam string TERM_NAMES [9] = '{
        "i_x", "i_y", "i_z", "j_x", "j_y", "j_z", "k_x", "k_y", "k_z"
    };

    // arctan(2^-i) in 2^-32 turn units
    localparam logic [31:0] ARCTAN_Q32 [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    t_basis basis_q [$];
    t_basis want_basis;
    t_basis got_basis;
    int     fails;
    int     reports;

    function automatic longint round_half_up(input longint v, input int sh);
        if (sh == 0) return v;
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint clamp_sym(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint mul_q30(input longint a, input longint b);
        return round_half_up(a * b, 30);
    endfunction

    function automatic t_term to_term(input longint v);
        longint r;
        r = round_half_up(v, 30 - FRAC_BITS);
        r = clamp_sym(r, longint'(1) <<< FRAC_BITS);
        return r[TERM_W-1:0];
    endfunction

    // cosine and sine at Q30 from a rotation-mode cordic on the low 30 bits
    function automatic void cordic_sincos(input t_angle ang, output longint cos_q30,
                                          output longint sin_q30);
        logic [31:0] turn;
        t_quad       quad;
        longint      x, y, z, dx, dy, c, s;
        turn = 32'(ang) << (32 - ANGLE_BITS);
        quad = t_quad'(turn[31:30]);
        z = longint'(turn[29:0]);
        x = GAIN_COMP_Q32;
        y = 0;
        for (int i = 0; i < TRIG_STAGES && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ARCTAN_Q32[i]);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ARCTAN_Q32[i]);
            end
        end
        c = round_half_up(clamp_sym(x, UNIT_Q32), 2);
        s = round_half_up(clamp_sym(y, UNIT_Q32), 2);
        case (quad)
            QUAD_0: begin cos_q30 = c;  sin_q30 = s;  end
            QUAD_1: begin cos_q30 = -s; sin_q30 = c;  end
            QUAD_2: begin cos_q30 = -c; sin_q30 = -s; end
            default: begin cos_q30 = s; sin_q30 = -c; end
        endcase
    endfunction

    function automatic t_basis rotation_basis(input t_angle yaw, input t_angle pitch,
                                              input t_angle roll);
        longint cy, sy, cp, sp, cr, sr;
        t_basis b;
        cordic_sincos(yaw, cy, sy);
        cordic_sincos(pitch, cp, sp);
        cordic_sincos(roll, cr, sr);
        b.i_x = to_term(mul_q30(cy, cp));
        b.i_y = to_term(mul_q30(sy, cp));
        b.i_z = to_term(-sp);
        b.j_x = to_term(-mul_q30(sy, cr) + mul_q30(mul_q30(sr, cy), sp));
        b.j_y = to_term(mul_q30(cy, cr) + mul_q30(mul_q30(sy, sp), sr));
        b.j_z = to_term(mul_q30(cp, sr));
        b.k_x = to_term(mul_q30(sy, sr) + mul_q30(mul_q30(cy, sp), cr));
        b.k_y = to_term(-mul_q30(cy, sr) + mul_q30(mul_q30(sy, sp), cr));
        b.k_z = to_term(mul_q30(cr, cp));
        return b;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            basis_q.delete();
            fails = 0;
            reports = 0;
            o_fail_count <= 0;
            o_pending <= 0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                basis_q.push_back(rotation_basis(i_req.yaw_angle, i_req.pitch_angle,
                                                 i_req.roll_angle));
            end
            if (i_res.valid && i_res.ready) begin
                got_basis = {i_res.i_x, i_res.i_y, i_res.i_z,
                             i_res.j_x, i_res.j_y, i_res.j_z,
                             i_res.k_x, i_res.k_y, i_res.k_z};
                if (basis_q.size() == 0) begin
                    fails++;
                    if (reports < MAX_REPORTS) begin
                        $display("unexpected result %h at %0t", got_basis, $realtime);
                    end
                    reports++;
                end else begin
                    want_basis = basis_q.pop_front();
                    // field k sits at slice 8-k of the packed basis
                    for (int k = 0; k < 9; k++) begin
                        if (got_basis[(8-k)*TERM_W +: TERM_W] !==
                            want_basis[(8-k)*TERM_W +: TERM_W]) begin
                            fails++;
                            if (reports < MAX_REPORTS) begin
                                $display("mismatch %s: expected %0d actual %0d at %0t",
                                         TERM_NAMES[k],
                                         $signed(want_basis[(8-k)*TERM_W +: TERM_W]),
                                         $signed(got_basis[(8-k)*TERM_W +: TERM_W]),
                                         $realtime);
                            end
                            reports++;
                        end
                    end
                end
            end
            o_pending <= basis_q.size();
            o_fail_count <= fails;
        end
    end

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives yaw, pitch, roll requests into the rotation basis core: a directed
// set of quadrant, gimbal-lock and bit-pattern angles, then random angles
// under three idle mixes on both channels, and gives the verdict from the
// checker beside the core.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import e2r_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int RANDOM_PER_MIX = 210;
    localparam int DIRECTED_COUNT = 21;

    localparam t_angle DIRECTED_ANGLES [DIRECTED_COUNT][3] = '{
        '{16'h0000, 16'h0000, 16'h0000}, '{16'hFFFF, 16'hFFFF, 16'hFFFF},
        '{16'h4000, 16'h0000, 16'h0000}, '{16'h8000, 16'h0000, 16'h0000},
        '{16'hC000, 16'h0000, 16'h0000}, '{16'h0000, 16'h4000, 16'h0000},
        '{16'h0000, 16'h8000, 16'h0000}, '{16'h0000, 16'hC000, 16'h0000},
        '{16'h0000, 16'h0000, 16'h4000}, '{16'h0000, 16'h0000, 16'h8000},
        '{16'h0000, 16'h0000, 16'hC000}, '{16'h2000, 16'h2000, 16'h2000},
        '{16'h4000, 16'h4000, 16'h4000}, '{16'h0000, 16'hC000, 16'h4000},
        '{16'h3FFF, 16'h4001, 16'hBFFF}, '{16'h7FFF, 16'h8001, 16'h0001},
        '{16'hC001, 16'hFFFE, 16'h3FFF}, '{16'h6000, 16'hE000, 16'hA000},
        '{16'h0001, 16'h0001, 16'h0001}, '{16'hAAAA, 16'h5555, 16'hCCCC},
        '{16'h5555, 16'hAAAA, 16'h3333}
    };

    logic i_clk;
    logic i_rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   fail_count;
    int   pending;
    int   cycles;

    e2r_in_if  req_if ();
    e2r_out_if res_if ();

    euler_to_rotation_matrix_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    e2r_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_res        (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // random angle biased toward quadrant edges and tiny angles
    function automatic t_angle pick_angle();
        case ($urandom_range(3))
            0: return t_angle'(($urandom_range(3) << 14) + $urandom_range(8) - 4);
            1: return t_angle'($urandom_range(63) - 32);
            default: return t_angle'($urandom);
        endcase
    endfunction

    task automatic send_angles(input t_angle yaw, input t_angle pitch, input t_angle roll);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.yaw_angle   <= yaw;
        req_if.pitch_angle <= pitch;
        req_if.roll_angle  <= roll;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    // result-side stalls
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        i_rst_n            <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.yaw_angle   <= '0;
        req_if.pitch_angle <= '0;
        req_if.roll_angle  <= '0;
        send_idle_pct = 28;
        recv_idle_pct = 85;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < DIRECTED_COUNT; n++) begin
            send_angles(DIRECTED_ANGLES[n][0], DIRECTED_ANGLES[n][1],
                        DIRECTED_ANGLES[n][2]);
        end

        // hold off new requests until the pipeline has emptied
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);

        for (int mix = 0; mix < 3; mix++) begin
            case (mix)
                0: begin send_idle_pct = 28; recv_idle_pct = 85; end
                1: begin send_idle_pct = 85; recv_idle_pct = 28; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int n = 0; n < RANDOM_PER_MIX; n++) begin
                send_angles(pick_angle(), pick_angle(), pick_angle());
            end
        end

        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
